[design/face_pose_and_quality_from_landmarks_assert.svh]
// Assertion macros used by the port-level checker of the face pose block.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef FACE_POSE_AND_QUALITY_FROM_LANDMARKS_ASSERT_SVH
`define FACE_POSE_AND_QUALITY_FROM_LANDMARKS_ASSERT_SVH

// Condition must hold at the same edge as the trigger.
`define FPQ_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition must hold at the edge after the trigger.
`define FPQ_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[design/fpq_pkg.sv]
// Shared types, constants and the arctangent table for the face pose block.
// No dependencies.
package fpq_pkg;

    localparam int ATAN_ITERATIONS = 16;
    localparam int DIV_QW          = 16;
    localparam int NCELL = (ATAN_ITERATIONS > DIV_QW) ? ATAN_ITERATIONS : DIV_QW;

    localparam int CW  = 34;   // CORDIC x/y width
    localparam int ZW  = 26;   // CORDIC angle accumulator width
    localparam int NW  = 36;   // divider numerator width
    localparam int DW  = 20;   // divider denominator width
    localparam int SHW = 5;    // shift index width

    localparam int ROLL_MAX  = 46080;
    localparam int YAW_MAX   = 7680;
    localparam int PITCH_MAX = 5120;
    localparam int QUAL_MAX  = 32768;
    localparam int YAW_GAIN  = 11520;
    localparam int PITCH_GAIN = 7680;
    localparam int Z_QUARTER = 90 * 65536;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic [NW-1:0]     rem;
        logic [NW-1:0]     dsh;
        logic [DW-1:0]     den;
        logic [DIV_QW-1:0] quo;
    } t_div;

    typedef struct packed {
        logic zero;
        logic yaw_neg;
        logic pitch_neg;
    } t_side;

    // atan(2^-i) in degrees, Q16, rounded
    function automatic logic signed [ZW-1:0] atan_q16(input logic [SHW-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = ZW'(2949120);
            5'd1:    v = ZW'(1740967);
            5'd2:    v = ZW'(919879);
            5'd3:    v = ZW'(466945);
            5'd4:    v = ZW'(234379);
            5'd5:    v = ZW'(117304);
            5'd6:    v = ZW'(58666);
            5'd7:    v = ZW'(29335);
            5'd8:    v = ZW'(14668);
            5'd9:    v = ZW'(7334);
            5'd10:   v = ZW'(3667);
            5'd11:   v = ZW'(1833);
            5'd12:   v = ZW'(917);
            5'd13:   v = ZW'(458);
            5'd14:   v = ZW'(229);
            5'd15:   v = ZW'(115);
            5'd16:   v = ZW'(57);
            5'd17:   v = ZW'(29);
            5'd18:   v = ZW'(14);
            5'd19:   v = ZW'(7);
            5'd20:   v = ZW'(4);
            5'd21:   v = ZW'(2);
            5'd22:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[design/fpq_cordic_cell.sv]
// One vectoring CORDIC micro-rotation with its output register.
// Depends on fpq_pkg.
module fpq_cordic_cell
    import fpq_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_adv,
    input  logic           i_act,
    input  logic [SHW-1:0] i_shift,
    input  t_cordic        i_data,
    output t_cordic        o_data
);

    t_cordic r_data;
    t_cordic n_data;
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] ang;

    always_comb begin
        x_in   = i_data.x;
        y_in   = i_data.y;
        xs     = x_in >>> i_shift;
        ys     = y_in >>> i_shift;
        ang    = atan_q16(i_shift);
        n_data = i_data;
        if (i_act) begin
            // rotate toward the x axis
            if (!y_in[CW-1]) begin
                n_data.x = x_in + ys;
                n_data.y = y_in - xs;
                n_data.z = i_data.z + ang;
            end else begin
                n_data.x = x_in - ys;
                n_data.y = y_in + xs;
                n_data.z = i_data.z - ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

[design/fpq_div_cell.sv]
// One restoring-division step (one quotient bit) with its output register.
// Depends on fpq_pkg.
module fpq_div_cell
    import fpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_adv,
    input  logic i_act,
    input  t_div i_data,
    output t_div o_data
);

    t_div r_data;
    t_div n_data;
    logic ge;

    always_comb begin
        ge     = (i_data.rem >= i_data.dsh);
        n_data = i_data;
        if (i_act) begin
            n_data.rem = ge ? (i_data.rem - i_data.dsh) : i_data.rem;
            n_data.dsh = i_data.dsh >> 1;
            n_data.quo = {i_data.quo[DIV_QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

[design/face_pose_and_quality_from_landmarks.sv]
// Face pose and quality: takes one detection per cycle unless stalled and
// returns roll, yaw, pitch and quality. Each item walks through stage 1,
// stage 2, a row of NCELL (16 by default) CORDIC and divider cells, one cell
// per cycle, and the output register. When the result at the output is
// stalled, the whole row holds. The frame height register may be written
// through the configuration port whenever the block is idle.
// Depends on fpq_pkg, fpq_cordic_cell and fpq_div_cell.
module face_pose_and_quality_from_landmarks
    import fpq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [11:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_left_eye_x,
    input  logic signed [15:0] i_left_eye_y,
    input  logic signed [15:0] i_right_eye_x,
    input  logic signed [15:0] i_right_eye_y,
    input  logic signed [15:0] i_nose_x,
    input  logic signed [15:0] i_nose_y,
    input  logic signed [15:0] i_left_mouth_y,
    input  logic signed [15:0] i_right_mouth_y,
    input  logic [15:0]        i_detection_score,
    input  logic [15:0]        i_box_height,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [16:0] o_roll_angle,
    output logic signed [13:0] o_yaw_angle,
    output logic signed [13:0] o_pitch_angle,
    output logic [15:0]        o_quality
);

    logic w_adv;
    logic [11:0] r_fh;

    // stage 1
    logic r_v1;
    logic signed [16:0] r1_dx, r1_dy;
    logic signed [17:0] r1_yaw_t;
    logic [15:0]        r1_span;
    logic signed [19:0] r1_pitch_t;
    logic [16:0]        r1_s2;
    logic [27:0]        r1_sf;
    logic [15:0]        r1_score, r1_box;
    logic [11:0]        r1_fh;

    logic signed [16:0] n1_dx, n1_dy, n1_e2, n1_m2;
    logic signed [17:0] n1_yaw_t, n1_s2raw;
    logic signed [19:0] n1_pitch_t;

    // stage 2
    logic    r_v2;
    t_cordic r2_c, n2_c;
    t_div    r2_yaw, r2_pitch, r2_qual, n2_yaw, n2_pitch, n2_qual;
    t_side   r2_sb, n2_sb;
    logic [17:0] yaw_abs;
    logic [19:0] pitch_abs;
    logic signed [CW-1:0] x0, y0;
    logic [NW-1:0] q_num;
    logic [DW-1:0] q_den;

    // cell row
    t_cordic w_c [NCELL+1];
    t_div    w_yaw [NCELL+1];
    t_div    w_pitch [NCELL+1];
    t_div    w_qual [NCELL+1];
    logic    r_vc [NCELL];
    t_side   r_sb [NCELL];

    // output stage
    logic r_ovld;
    logic signed [16:0] r_roll, n_roll;
    logic signed [13:0] r_yaw, n_yaw, r_pitch, n_pitch;
    logic [15:0] r_qual, n_qual;
    logic signed [ZW-1:0] z_rnd;
    logic [DIV_QW-1:0] yaw_mag, pitch_mag;
    t_cordic c_last;
    t_div    yaw_last, pitch_last, qual_last;
    t_side   sb_last;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_ovld & i_stall;
    assign w_adv       = ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fh <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_fh <= i_cfg_data;
        end
    end

    // ---------------- stage 1: differences and the score product
    always_comb begin
        n1_dx      = 17'(i_right_eye_x) - 17'(i_left_eye_x);
        n1_dy      = 17'(i_right_eye_y) - 17'(i_left_eye_y);
        n1_yaw_t   = (18'(i_nose_x) <<< 1) - 18'(i_left_eye_x) - 18'(i_right_eye_x);
        n1_e2      = 17'(i_left_eye_y) + 17'(i_right_eye_y);
        n1_m2      = 17'(i_left_mouth_y) + 17'(i_right_mouth_y);
        n1_s2raw   = 18'(n1_m2) - 18'(n1_e2);
        n1_pitch_t = (20'(i_nose_y) <<< 2) - 20'(n1_e2) - 20'(n1_m2);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_dx      <= n1_dx;
            r1_dy      <= n1_dy;
            r1_yaw_t   <= n1_yaw_t;
            // hold the eye span at no less than one pixel
            r1_span    <= (n1_dx < 17'sd16) ? 16'd16 : n1_dx[15:0];
            r1_s2      <= (n1_s2raw < 18'sd32) ? 17'd32 : n1_s2raw[16:0];
            r1_pitch_t <= n1_pitch_t;
            r1_sf      <= 28'(i_detection_score) * 28'(r_fh);
            r1_score   <= i_detection_score;
            r1_box     <= i_box_height;
            r1_fh      <= r_fh;
        end
    end

    // ---------------- stage 2: numerators, divisors, CORDIC start vector
    always_comb begin
        yaw_abs   = r1_yaw_t[17] ? 18'(-r1_yaw_t) : 18'(r1_yaw_t);
        pitch_abs = r1_pitch_t[19] ? 20'(-r1_pitch_t) : 20'(r1_pitch_t);

        if (r1_fh != '0) begin
            q_num = NW'(r1_sf) * NW'(13) + NW'(r1_box) * NW'(14336) + NW'(r1_fh) * NW'(10);
            q_den = DW'(r1_fh) * DW'(20);
        end else begin
            q_num = NW'(r1_score) * NW'(13) + NW'(10);
            q_den = DW'(20);
        end

        n2_yaw.rem = NW'(yaw_abs) * NW'(YAW_GAIN) + NW'(r1_span >> 1);
        n2_yaw.den = DW'(r1_span);
        n2_yaw.dsh = NW'(r1_span) << (DIV_QW - 1);
        n2_yaw.quo = '0;

        n2_pitch.rem = NW'(pitch_abs) * NW'(PITCH_GAIN) + NW'(r1_s2 >> 1);
        n2_pitch.den = DW'(r1_s2);
        n2_pitch.dsh = NW'(r1_s2) << (DIV_QW - 1);
        n2_pitch.quo = '0;

        n2_qual.rem = q_num;
        n2_qual.den = q_den;
        n2_qual.dsh = NW'(q_den) << (DIV_QW - 1);
        n2_qual.quo = '0;

        x0 = CW'(r1_dx) <<< 14;
        y0 = CW'(r1_dy) <<< 14;
        // left half plane: turn by a quarter first
        if (r1_dx[16]) begin
            if (!r1_dy[16]) begin
                n2_c.x = y0;
                n2_c.y = -x0;
                n2_c.z = ZW'(Z_QUARTER);
            end else begin
                n2_c.x = -y0;
                n2_c.y = x0;
                n2_c.z = -ZW'(Z_QUARTER);
            end
        end else begin
            n2_c.x = x0;
            n2_c.y = y0;
            n2_c.z = '0;
        end

        n2_sb.zero      = (r1_dx == '0) && (r1_dy == '0);
        n2_sb.yaw_neg   = r1_yaw_t[17];
        n2_sb.pitch_neg = r1_pitch_t[19];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_c     <= n2_c;
            r2_yaw   <= n2_yaw;
            r2_pitch <= n2_pitch;
            r2_qual  <= n2_qual;
            r2_sb    <= n2_sb;
        end
    end

    // ---------------- cell row
    assign w_c[0]     = r2_c;
    assign w_yaw[0]   = r2_yaw;
    assign w_pitch[0] = r2_pitch;
    assign w_qual[0]  = r2_qual;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        fpq_cordic_cell u_cordic (
            .i_clk   (i_clk),
            .i_adv   (w_adv),
            .i_act   (k < ATAN_ITERATIONS),
            .i_shift (SHW'(k)),
            .i_data  (w_c[k]),
            .o_data  (w_c[k+1])
        );
        fpq_div_cell u_div_yaw (
            .i_clk  (i_clk),
            .i_adv  (w_adv),
            .i_act  (k < DIV_QW),
            .i_data (w_yaw[k]),
            .o_data (w_yaw[k+1])
        );
        fpq_div_cell u_div_pitch (
            .i_clk  (i_clk),
            .i_adv  (w_adv),
            .i_act  (k < DIV_QW),
            .i_data (w_pitch[k]),
            .o_data (w_pitch[k+1])
        );
        fpq_div_cell u_div_qual (
            .i_clk  (i_clk),
            .i_adv  (w_adv),
            .i_act  (k < DIV_QW),
            .i_data (w_qual[k]),
            .o_data (w_qual[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sb[k] <= (k == 0) ? r2_sb : r_sb[(k == 0) ? 0 : k-1];
            end
        end
    end

    // ---------------- valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_ovld <= 1'b0;
            for (int k = 0; k < NCELL; k++) begin
                r_vc[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_vc[0] <= r_v2;
            for (int k = 1; k < NCELL; k++) begin
                r_vc[k] <= r_vc[k-1];
            end
            r_ovld <= r_vc[NCELL-1];
        end
    end

    // ---------------- output stage: round, saturate, apply sign
    always_comb begin
        c_last     = w_c[NCELL];
        yaw_last   = w_yaw[NCELL];
        pitch_last = w_pitch[NCELL];
        qual_last  = w_qual[NCELL];
        sb_last    = r_sb[NCELL-1];

        z_rnd = (c_last.z + ZW'(128)) >>> 8;
        if (sb_last.zero) begin
            n_roll = '0;
        end else if (z_rnd > ZW'(ROLL_MAX)) begin
            n_roll = 17'(ROLL_MAX);
        end else if (z_rnd < -ZW'(ROLL_MAX)) begin
            n_roll = -17'(ROLL_MAX);
        end else begin
            n_roll = z_rnd[16:0];
        end

        // a remainder still at or above the divisor means the quotient overflowed
        if ((yaw_last.rem >= NW'(yaw_last.den)) || (yaw_last.quo > DIV_QW'(YAW_MAX))) begin
            yaw_mag = DIV_QW'(YAW_MAX);
        end else begin
            yaw_mag = yaw_last.quo;
        end
        n_yaw = sb_last.yaw_neg ? -14'(yaw_mag) : 14'(yaw_mag);

        if ((pitch_last.rem >= NW'(pitch_last.den))
            || (pitch_last.quo > DIV_QW'(PITCH_MAX))) begin
            pitch_mag = DIV_QW'(PITCH_MAX);
        end else begin
            pitch_mag = pitch_last.quo;
        end
        n_pitch = sb_last.pitch_neg ? -14'(pitch_mag) : 14'(pitch_mag);

        if ((qual_last.rem >= NW'(qual_last.den))
            || (17'(qual_last.quo) > 17'(QUAL_MAX))) begin
            n_qual = 16'(QUAL_MAX);
        end else begin
            n_qual = 16'(qual_last.quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_roll  <= n_roll;
            r_yaw   <= n_yaw;
            r_pitch <= n_pitch;
            r_qual  <= n_qual;
        end
    end

    assign o_valid       = r_ovld;
    assign o_roll_angle  = r_roll;
    assign o_yaw_angle   = r_yaw;
    assign o_pitch_angle = r_pitch;
    assign o_quality     = r_qual;

endmodule

[design/fpq_checker.sv]
// Port-level checker for the face pose block, bound to the top level.
// Depends on the assertion macro header.
`include "face_pose_and_quality_from_landmarks_assert.svh"

module fpq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [11:0]        i_cfg_data,
    input logic               i_valid,
    input logic               o_stall,
    input logic signed [15:0] i_left_eye_x,
    input logic signed [15:0] i_left_eye_y,
    input logic signed [15:0] i_right_eye_x,
    input logic signed [15:0] i_right_eye_y,
    input logic signed [15:0] i_nose_x,
    input logic signed [15:0] i_nose_y,
    input logic signed [15:0] i_left_mouth_y,
    input logic signed [15:0] i_right_mouth_y,
    input logic [15:0]        i_detection_score,
    input logic [15:0]        i_box_height,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [16:0] o_roll_angle,
    input logic signed [13:0] o_yaw_angle,
    input logic signed [13:0] o_pitch_angle,
    input logic [15:0]        o_quality
);

    `FPQ_ASSERT_NEXT(a_hold_valid, o_valid && i_stall, o_valid, "result dropped while stalled")
    `FPQ_ASSERT_NOW(a_no_idle_stall, !o_valid, !o_stall, "input stalled with empty output")
    `FPQ_ASSERT_NOW(a_pose_range, o_valid, (o_yaw_angle >= -14'sd7680) && (o_yaw_angle <= 14'sd7680) && (o_pitch_angle >= -14'sd5120) && (o_pitch_angle <= 14'sd5120), "pose out of range")
    `FPQ_ASSERT_NOW(a_qual_range, o_valid, (o_quality <= 16'd32768) && (o_roll_angle >= -17'sd46080) && (o_roll_angle <= 17'sd46080), "quality or roll out of range")

endmodule

bind face_pose_and_quality_from_landmarks fpq_checker u_fpq_checker (.*);

[tb/sv/fpq_checker.sv]
// Checker for the face pose block: watches the landmark and result channels,
// predicts roll, yaw, pitch and quality for each detection, and compares.
// Depends on fpq_pkg for ATAN_ITERATIONS and the output limits.
`timescale 1ns / 100ps
module fpq_tb_checker
    import fpq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [11:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic               i_stall,
    input  logic signed [15:0] i_lx,
    input  logic signed [15:0] i_ly,
    input  logic signed [15:0] i_rx,
    input  logic signed [15:0] i_ry,
    input  logic signed [15:0] i_nx,
    input  logic signed [15:0] i_ny,
    input  logic signed [15:0] i_lmy,
    input  logic signed [15:0] i_rmy,
    input  logic [15:0]        i_score,
    input  logic [15:0]        i_box,
    input  logic               o_valid,
    input  logic               o_stall,
    input  logic signed [16:0] o_roll,
    input  logic signed [13:0] o_yaw,
    input  logic signed [13:0] o_pitch,
    input  logic [15:0]        o_quality,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic signed [16:0] roll;
        logic signed [13:0] yaw;
        logic signed [13:0] pitch;
        logic [15:0]        quality;
    } t_pose;

    t_pose       pose_q[$];
    logic [11:0] frame_h;

    localparam longint ATAN_DEG[24] = '{2949120, 1740967, 919879, 466945, 234379,
        117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0};

    function automatic longint div_round(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint limit(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint eye_roll(longint dx, longint dy);
        longint x, y, z, t, xs, ys;
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        x = dx * 16384;
        y = dy * 16384;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 90 * 65536;
            end else begin
                x = -y; y = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < ATAN_ITERATIONS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += ATAN_DEG[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_DEG[i];
            end
        end
        return limit((z + 128) >>> 8, -ROLL_MAX, ROLL_MAX);
    endfunction

    function automatic t_pose predict_pose();
        t_pose  p;
        longint lx, ly, rx, ry, span, e2, m2, s2, q, fh;
        lx = i_lx; ly = i_ly; rx = i_rx; ry = i_ry; fh = frame_h;
        p.roll = 17'(eye_roll(rx - lx, ry - ly));
        span = (rx - lx < 16) ? 16 : rx - lx;
        p.yaw = 14'(limit(div_round(longint'(YAW_GAIN) * (2 * longint'(i_nx) - lx - rx),
                                    span), -YAW_MAX, YAW_MAX));
        e2 = ly + ry;
        m2 = longint'(i_lmy) + longint'(i_rmy);
        s2 = (m2 - e2 < 32) ? 32 : m2 - e2;
        p.pitch = 14'(limit(div_round(longint'(PITCH_GAIN) * (4 * longint'(i_ny) - e2 - m2),
                                      s2), -PITCH_MAX, PITCH_MAX));
        if (fh != 0)
            q = div_round(13 * longint'(i_score) * fh + 14336 * longint'(i_box), 20 * fh);
        else
            q = div_round(13 * longint'(i_score), 20);
        p.quality = 16'(limit(q, 0, QUAL_MAX));
        return p;
    endfunction

    assign o_pending = pose_q.size();

    always @(posedge i_clk) begin
        t_pose want;
        int    errs;
        errs = 0;
        if (!i_rst_n) begin
            frame_h <= '0;
            o_fail_count <= 0;
            pose_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) frame_h <= i_cfg_data;
            if (i_valid && !o_stall) pose_q.push_back(predict_pose());
            if (o_valid && !i_stall) begin
                if (pose_q.size() == 0) begin
                    $error("result with nothing expected");
                    errs++;
                end else begin
                    want = pose_q.pop_front();
                    if (o_roll !== want.roll) begin
                        $error("roll_angle exp %0d got %0d", want.roll, o_roll);
                        errs++;
                    end
                    if (o_yaw !== want.yaw) begin
                        $error("yaw_angle exp %0d got %0d", want.yaw, o_yaw);
                        errs++;
                    end
                    if (o_pitch !== want.pitch) begin
                        $error("pitch_angle exp %0d got %0d", want.pitch, o_pitch);
                        errs++;
                    end
                    if (o_quality !== want.quality) begin
                        $error("quality exp %0d got %0d", want.quality, o_quality);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

[tb/sv/tb_top.sv]
// Top of the face pose testbench: clock, reset, landmark stimulus, result
// stalls and verdict. Depends on the block, fpq_pkg and fpq_tb_checker.
`timescale 1ns / 100ps
module tb_top;
    import fpq_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [11:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] lx, ly, rx, ry, nx, ny, lmy, rmy;
    logic [15:0]        score, box;
    logic               o_valid;
    logic               i_stall;
    logic signed [16:0] roll;
    logic signed [13:0] yaw, pitch;
    logic [15:0]        quality;
    int                 fail_count;
    int                 pending;
    bit                 hold_off;

    face_pose_and_quality_from_landmarks u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_left_eye_x(lx), .i_left_eye_y(ly), .i_right_eye_x(rx), .i_right_eye_y(ry),
        .i_nose_x(nx), .i_nose_y(ny), .i_left_mouth_y(lmy), .i_right_mouth_y(rmy),
        .i_detection_score(score), .i_box_height(box),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_roll_angle(roll), .o_yaw_angle(yaw), .o_pitch_angle(pitch),
        .o_quality(quality)
    );

    fpq_tb_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_stall(i_stall),
        .i_lx(lx), .i_ly(ly), .i_rx(rx), .i_ry(ry), .i_nx(nx), .i_ny(ny),
        .i_lmy(lmy), .i_rmy(rmy), .i_score(score), .i_box(box),
        .o_valid(o_valid), .o_stall(o_stall),
        .o_roll(roll), .o_yaw(yaw), .o_pitch(pitch), .o_quality(quality),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic write_rows(input logic [11:0] fh);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= fh;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid for a random gap unless this item goes out back to back, then
    // present one detection and wait for its transaction.
    task automatic send_face(input logic [15:0] f[10]);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        {lx, ly, rx, ry, nx, ny, lmy, rmy, score, box} =
            {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9]};
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    function automatic logic [15:0] any_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            default: return 16'($signed(16'($urandom_range(0, 4000))) - 16'sd2000);
        endcase
    endfunction

    // Plausible face (eyes side by side, nose between, mouth below) or noise.
    function automatic void make_face(output logic [15:0] f[10]);
        int cx, cy, span, drop, tilt;
        if ($urandom_range(0, 4) == 0) begin
            for (int k = 0; k < 8; k++) f[k] = any_coord();
        end else begin
            cx = $urandom_range(0, 20000) - 10000;
            cy = $urandom_range(0, 20000) - 10000;
            span = $urandom_range(0, 1200) - 100;
            tilt = $urandom_range(0, 800) - 400;
            drop = $urandom_range(0, 1000) - 100;
            f[0] = 16'(cx - span / 2);
            f[1] = 16'(cy - tilt / 2);
            f[2] = 16'(cx + span / 2);
            f[3] = 16'(cy + tilt / 2);
            f[4] = 16'(cx + $urandom_range(0, 600) - 300);
            f[5] = 16'(cy + $urandom_range(0, 600) - 200);
            f[6] = 16'(cy + drop + $urandom_range(0, 40) - 20);
            f[7] = 16'(cy + drop + $urandom_range(0, 40) - 20);
        end
        f[8] = $urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768));
        f[9] = 16'($urandom);
    endfunction

    initial begin
        logic [15:0] f[10];
        logic [11:0] heights[5] = '{12'd0, 12'd4095, 12'd1, 12'd1080, 12'd480};
        i_rst_n = 1'b0; i_cfg_valid = 1'b0; i_cfg_data = '0; i_valid = 1'b0;
        {lx, ly, rx, ry, nx, ny, lmy, rmy, score, box} = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: frame height zero from reset, then extremes.
        f = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd32768, 16'd0};
        send_face(f);   // coincident eyes, mouth on eye line
        f = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
              16'h8000, 16'h8000, 16'hffff, 16'hffff};
        send_face(f);
        f = '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
              16'h7fff, 16'h7fff, 16'h0000, 16'hffff};
        send_face(f);   // eyes reversed
        f = '{16'd100, 16'd0, 16'd0, 16'd50, 16'd40, 16'd0, 16'd300, 16'd300, 16'd100, 16'd10};
        send_face(f);   // dx < 0, dy > 0
        f = '{16'd100, 16'd50, 16'd0, 16'd0, 16'd40, 16'd0, 16'd300, 16'd300, 16'd20000, 16'd9};
        send_face(f);   // dx < 0, dy < 0
        f = '{16'd0, 16'd0, 16'd0, 16'd64, 16'd0, 16'd0, 16'hffc0, 16'hffc0, 16'd1, 16'd1};
        send_face(f);   // vertical eyes, mouth above
        f = '{16'd0, 16'd0, 16'd0, 16'hffc0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2, 16'd2};
        send_face(f);
        f = '{16'd0, 16'd0, 16'd16, 16'd0, 16'd8, 16'd100, 16'd200, 16'd200, 16'd32767, 16'd0};
        send_face(f);   // one pixel span
        f = '{16'd0, 16'd0, 16'hfff0, 16'd0, 16'd8, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        send_face(f);   // negative x along axis
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            write_rows(heights[phase]);
            if (phase == 1) begin
                f = '{16'd0, 16'd0, 16'd100, 16'd0, 16'd50, 16'd100, 16'd200, 16'd200,
                      16'd32768, 16'hffff};
                send_face(f);   // quality clamps at full frame
                f = '{16'd0, 16'd0, 16'd100, 16'd0, 16'd50, 16'd100, 16'd200, 16'd200,
                      16'hffff, 16'hffff};
                send_face(f);   // score above 1.0
            end
            if (phase == 2) hold_off = 1'b1;
            for (int n = 0; n < 80; n++) begin
                make_face(f);
                send_face(f);
            end
            drain();
        end
        if (fail_count == 0) $display("PASS face_pose_and_quality_from_landmarks");
        else $display("FAIL face_pose_and_quality_from_landmarks");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off that fills the pipe.
    initial begin
        int wait_n;
        i_stall = 1'b0;
        hold_off = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                hold_off = 1'b0;
                i_stall <= 1'b1;
                repeat (120) @(negedge i_clk);
            end
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
            if (wait_n > 0) begin
                i_stall <= 1'b1;
                repeat (wait_n - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        #5ms;
        $display("FAIL face_pose_and_quality_from_landmarks");
        $finish;
    end

endmodule
